// ----- hdl/assert_macros.svh -----
// Assertion helpers for the name table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/nametbl_pkg.sv -----
// ----------------------------------------------------------------------------
// nametbl_pkg
// Types and codes shared by the name table core and its cells.
// ----------------------------------------------------------------------------
package nametbl_pkg;

  localparam int KEY_FULL_W = 64;
  localparam int ID_W       = 6;

  // request codes
  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_LOOKUP   = 2'd1;

  // response codes
  localparam logic [1:0] ST_ACK      = 2'd0;
  localparam logic [1:0] ST_FOUND    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [KEY_FULL_W-1:0] name_key;
    logic [ID_W-1:0]       src_id;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] task_id;
  } rsp_t;

  // request token walking down the cell chain
  typedef struct packed {
    logic            active;  // token present in this stage
    logic [1:0]      cmd;
    logic            drop;    // register on a full table: no response
    logic            hit;     // register: key matched; lookup: found
    logic            append;  // register: key appended at the count slot
    logic [ID_W-1:0] id;      // register: source id; lookup: found id
  } tok_t;

endpackage

// ----- hdl/name_to_id_register_lookup_table_core.sv -----
// ----------------------------------------------------------------------------
// name_to_id_register_lookup_table_core
// Append-only name-to-task-id table built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one word: cmd, name_key,
//   src_id. rsp channel (rsp_valid/rsp_ready/rsp) returns status and
//   task_id. A register request on a full table returns no word at all.
//   Each accepted word is latched, then walks the chain one cell per cycle;
//   cell i owns table slot i and compares, updates or appends as the word
//   passes. From the chain tail the word is loaded into the rsp register.
//   One word is in the chain at a time, so a new word is taken only after
//   the last one has left the chain tail; the spacing of accepted words is
//   set by the length of the cell chain.
//   Reset empties the table (count to zero) and clears all valid flags; slot
//   contents are left as they are and never read above the count.
//   If rsp_ready is low while a response waits, the finished word holds at
//   the chain tail and req_ready stays low until the rsp register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module name_to_id_register_lookup_table_core
  import nametbl_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int NAME_CHARS  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int KEY_W = 8 * NAME_CHARS;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  // chain stage chain_tok[0] is the input latch, chain_tok[i+1] is the output of cell i
  tok_t             chain_tok [TABLE_DEPTH+1];
  logic [KEY_W-1:0] chain_key [TABLE_DEPTH+1];

  logic [CNT_W-1:0] count;
  logic             busy;
  logic             accept;
  logic             take;
  logic             advance;
  tok_t             tail;
  tok_t             head_next;
  rsp_t             rsp_next;

  assign accept    = req_valid && req_ready;
  assign req_ready = !busy;
  assign tail      = chain_tok[TABLE_DEPTH];
  // the tail moves into the rsp register only when that register is free
  assign take      = tail.active && (!rsp_valid || rsp_ready);
  assign advance   = !(tail.active && !take);

  always_comb begin
    head_next        = '0;
    head_next.active = accept;
    head_next.cmd    = req.cmd;
    head_next.drop   = (req.cmd == CMD_REGISTER) && (count == FULL_COUNT);
    // lookups start with id 0 so not-found falls out naturally
    head_next.id     = (req.cmd == CMD_REGISTER) ? req.src_id : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_tok[0].active <= 1'b0;
    end else if (advance) begin
      chain_tok[0] <= head_next;
    end
  end

  // high name bytes beyond NAME_CHARS are cut here, before store and compare
  always_ff @(posedge clk) begin
    if (advance) begin
      chain_key[0] <= req.name_key[KEY_W-1:0];
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    nametbl_cell #(
      .KEY_W (KEY_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .slot    (CNT_W'(i)),
      .count   (count),
      .up_tok  (chain_tok[i]),
      .up_key  (chain_key[i]),
      .dn_tok  (chain_tok[i+1]),
      .dn_key  (chain_key[i+1])
    );
  end

  always_comb begin
    rsp_next = '0;
    unique case (tail.cmd)
      CMD_REGISTER: rsp_next.status = ST_ACK;
      CMD_LOOKUP: begin
        rsp_next.status  = tail.hit ? ST_FOUND : ST_NOTFOUND;
        rsp_next.task_id = tail.hit ? tail.id : '0;
      end
      default: rsp_next.status = ST_BAD;
    endcase
  end

  // busy covers the whole trip from acceptance to the rsp register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (take) begin
        busy <= 1'b0;
      end
      if (take && tail.append) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take && !tail.drop) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !tail.drop) begin
      rsp <= rsp_next;
    end
  end

  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= FULL_COUNT)
  `ASSERT_IMPL(a_append_room, clk, rst, tail.active && tail.append, count < FULL_COUNT)
  `ASSERT_NEXT(a_one_in_flight, clk, rst, accept, !req_ready && chain_tok[0].active)

endmodule

// ----- hdl/nametbl_cell.sv -----
// ----------------------------------------------------------------------------
// nametbl_cell
// One table slot plus one stage of the request chain.
// ----------------------------------------------------------------------------
module nametbl_cell
  import nametbl_pkg::*;
#(
  parameter int KEY_W = 64,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [CNT_W-1:0] slot,
  input  logic [CNT_W-1:0] count,
  input  tok_t             up_tok,
  input  logic [KEY_W-1:0] up_key,
  output tok_t             dn_tok,
  output logic [KEY_W-1:0] dn_key
);

  logic [KEY_W-1:0] entry_name;
  logic [ID_W-1:0]  entry_id;
  logic             match;
  logic             do_update;
  logic             do_append;
  tok_t             dn_tok_next;

  assign match = (slot < count) && (entry_name == up_key);

  always_comb begin
    dn_tok_next = up_tok;
    do_update   = 1'b0;
    do_append   = 1'b0;
    if (up_tok.active && !up_tok.drop) begin
      if (up_tok.cmd == CMD_REGISTER) begin
        if (match) begin
          do_update       = 1'b1;
          dn_tok_next.hit = 1'b1;
        end
        // all live slots sit ahead of the count slot, so hit is final here
        if ((slot == count) && !up_tok.hit) begin
          do_append          = 1'b1;
          dn_tok_next.append = 1'b1;
        end
      end else if (up_tok.cmd == CMD_LOOKUP) begin
        if (match && !up_tok.hit) begin
          dn_tok_next.hit = 1'b1;
          dn_tok_next.id  = entry_id;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_tok.active <= 1'b0;
    end else if (advance) begin
      dn_tok <= dn_tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dn_key <= up_key;
      if (do_append) begin
        entry_name <= up_key;
      end
      if (do_update || do_append) begin
        entry_id <= up_tok.id;
      end
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the name-to-id table core. A shadow copy of the
// table predicts each reply, and the reply stream is compared word by word.
// Directed words cover the extremes, random traffic exercises hits and
// near misses, and a final phase runs the table full.
// ----------------------------------------------------------------------------
module testbench
  import nametbl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH      = 32;
  localparam int NCHARS         = 8;
  localparam int FRESH_CAP      = 26;      // random phase stops appending here
  localparam int TIMEOUT_CYCLES = 600000;

  // request codes the block does not use; both answer bad
  localparam logic [1:0] CMD_SPARE2 = 2'd2;
  localparam logic [1:0] CMD_SPARE3 = 2'd3;

  // only the low NCHARS bytes of a key are stored and compared
  localparam logic [KEY_FULL_W-1:0] KEY_MASK =
    (NCHARS >= 8) ? {KEY_FULL_W{1'b1}} : ((64'd1 << (8 * NCHARS)) - 64'd1);

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  name_to_id_register_lookup_table_core #(
    .TABLE_DEPTH(TBL_DEPTH),
    .NAME_CHARS (NCHARS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow table and reply prediction
  // --------------------------------------------------------------------------
  logic [KEY_FULL_W-1:0] shadow_names [TBL_DEPTH];
  logic [ID_W-1:0]       shadow_ids   [TBL_DEPTH];
  int                    shadow_count = 0;

  rsp_t                  expected_replies [$];
  logic [KEY_FULL_W-1:0] key_pool [$];   // keys worth looking up again
  int                    err_count = 0;

  // Shared knobs between the test sequence and the two handshake sides.
  bit steady_flow  = 1'b0;   // no random idling on either side while set
  int rsp_hold_req = 0;      // long receiver hold-off, in cycles

  // Apply one accepted request word to the shadow table and queue its reply.
  // A register on a full table is dropped: nothing is queued.
  function automatic void predict_reply(input req_t w);
    logic [KEY_FULL_W-1:0] key;
    rsp_t                  reply;
    bit                    hit;
    int                    n;
    key   = w.name_key & KEY_MASK;
    reply = '0;
    hit   = 1'b0;
    n     = shadow_count;
    case (w.cmd)
      CMD_REGISTER: begin
        if (n >= TBL_DEPTH) return;
        // every stored copy of the key takes the new id
        for (int i = 0; i < n; i++) begin
          if (shadow_names[i] == key) begin
            shadow_ids[i] = w.src_id;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          shadow_names[n] = key;
          shadow_ids[n]   = w.src_id;
          shadow_count    = n + 1;
        end
        reply.status = ST_ACK;
      end
      CMD_LOOKUP: begin
        // first match in slot order wins
        reply.status = ST_NOTFOUND;
        for (int i = 0; i < n; i++) begin
          if (!hit && shadow_names[i] == key) begin
            reply.status  = ST_FOUND;
            reply.task_id = shadow_ids[i];
            hit = 1'b1;
          end
        end
      end
      default: begin
        reply.status = ST_BAD;
      end
    endcase
    expected_replies.push_back(reply);
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Idle lengths: mostly short, now and then long
  // --------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_FULL_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom_range(0, 63));
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Called right after a rising edge; returns right after the
  // edge that took the word. valid stays high into the next word when no gap
  // is drawn, so it is never lowered and raised within one step.
  // --------------------------------------------------------------------------
  task automatic send_req(input logic [1:0] op, input logic [KEY_FULL_W-1:0] key,
                          input logic [ID_W-1:0] sid);
    int   gap;
    req_t w;
    w   = '{cmd: op, name_key: key, src_id: sid};
    gap = (steady_flow || $urandom_range(0, 99) < 50) ? 0 : idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
    predict_reply(w);
  endtask

  // Stop offering, wait for every queued reply, then cover the chain length
  // in case a dropped register is still walking the cells.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (TBL_DEPTH + 6) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Response side: random stalls, plus a long counted hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : rsp_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rsp_hold_req > 0) begin
        stall_left   = rsp_hold_req;
        rsp_hold_req = 0;
      end else if (stall_left == 0 && !steady_flow && !rst &&
                   $urandom_range(0, 99) < 25) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Every word taken from the rsp channel is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin : reply_check
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("reply with none pending: status=%0d task_id=%0d",
                                  rsp.status, rsp.task_id));
      end else begin
        want = expected_replies.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
        if (rsp.task_id !== want.task_id)
          report_mismatch($sformatf("task_id got %0d want %0d (status %0d)",
                                    rsp.task_id, want.task_id, want.status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Short name 'R','W','f','n' packed little-endian: 'R' in the low byte.
  localparam logic [KEY_FULL_W-1:0] KEY_SHORT = {32'd0, "nfWR"};
  localparam logic [KEY_FULL_W-1:0] KEY_LONG  = "nfWRnfWR";

  // Empty table: lookups miss, spare codes answer bad.
  task automatic test_empty_table();
    send_req(CMD_LOOKUP, '0, '0);
    send_req(CMD_LOOKUP, '1, '1);
    send_req(CMD_SPARE2, '1, '1);
    send_req(CMD_SPARE3, '0, '0);
  endtask

  // Append keys at the field extremes, read back all but the zero key, and try near misses.
  task automatic test_register_lookup();
    send_req(CMD_REGISTER, '0, 6'd63);
    send_req(CMD_REGISTER, '1, 6'd0);
    send_req(CMD_REGISTER, KEY_SHORT, 6'd21);
    send_req(CMD_REGISTER, KEY_LONG, 6'd42);
    key_pool.push_back('0);
    key_pool.push_back('1);
    key_pool.push_back(KEY_SHORT);
    key_pool.push_back(KEY_LONG);
    send_req(CMD_LOOKUP, '1, 6'd5);
    send_req(CMD_LOOKUP, KEY_SHORT, 6'd0);
    send_req(CMD_LOOKUP, KEY_LONG, 6'd63);
    // near misses: one byte past the short name, and the top key bit
    send_req(CMD_LOOKUP, KEY_SHORT | (64'h1 << 32), 6'd0);
    send_req(CMD_LOOKUP, KEY_LONG ^ (64'h1 << 63), 6'd0);
  endtask

  // Re-register stored keys: ack, and the lookup sees the new id; a spare code changes nothing.
  task automatic test_duplicate_register();
    send_req(CMD_REGISTER, KEY_SHORT, 6'd7);
    send_req(CMD_LOOKUP, KEY_SHORT, 6'd0);
    send_req(CMD_REGISTER, '0, 6'd0);
    send_req(CMD_LOOKUP, '0, 6'd63);   // found with id 0, not a miss
    send_req(CMD_SPARE3, KEY_SHORT, 6'd9);
    send_req(CMD_LOOKUP, KEY_SHORT, 6'd1);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the chain backs up and req_ready drops. Then the sender waits for
  // every reply before moving on.
  task automatic test_backpressure();
    steady_flow  = 1'b1;
    rsp_hold_req = 300;
    for (int i = 0; i < 6; i++)
      send_req(CMD_LOOKUP, key_pool[i % key_pool.size()], rand_id());
    steady_flow = 1'b0;
    wait_drained();
  endtask

  // Random mix of register, lookup and spare codes. Keys come mostly from
  // the pool so that hits and updates are common; some are fresh, some one
  // bit away from a known key. Once the table nears full, registers only
  // update stored keys so the full case is saved for its own test.
  task automatic run_random_mix(input int count);
    int                    sel;
    logic [1:0]            op;
    logic [KEY_FULL_W-1:0] key;
    bit                    is_new;
    for (int i = 0; i < count; i++) begin
      steady_flow = ((i / 40) % 4 == 3);
      sel = $urandom_range(0, 99);
      if (sel < 40)      op = CMD_REGISTER;
      else if (sel < 85) op = CMD_LOOKUP;
      else               op = $urandom_range(0, 1) ? CMD_SPARE3 : CMD_SPARE2;
      sel    = $urandom_range(0, 99);
      is_new = (sel < 30);
      if (sel < 15)
        key = rand_key();
      else if (sel < 30)
        key = key_pool[$urandom_range(0, key_pool.size() - 1)] ^
              (64'h1 << $urandom_range(0, 63));
      else
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (op == CMD_REGISTER && shadow_count >= FRESH_CAP && shadow_count < TBL_DEPTH) begin
        key    = shadow_names[$urandom_range(0, shadow_count - 1)];
        is_new = 1'b0;
      end
      if (op == CMD_REGISTER && is_new) key_pool.push_back(key);
      send_req(op, key, rand_id());
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_mix(300);
  endtask

  // Fill every slot, then check that registers on a full table are dropped
  // silently (stored keys included) and leave the table as it was.
  task automatic test_table_full();
    logic [KEY_FULL_W-1:0] key;
    while (shadow_count < TBL_DEPTH) begin
      key = rand_key();
      key_pool.push_back(key);
      send_req(CMD_REGISTER, key, rand_id());
    end
    send_req(CMD_REGISTER, shadow_names[0], ~shadow_ids[0]);
    send_req(CMD_REGISTER, rand_key(), 6'd63);
    send_req(CMD_LOOKUP, shadow_names[0], 6'd0);
    send_req(CMD_LOOKUP, shadow_names[TBL_DEPTH-1], 6'd0);
    run_random_mix(120);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_register_lookup();
    test_duplicate_register();
    test_backpressure();
    test_random_traffic();
    test_table_full();
    wait_drained();
    if (err_count == 0) begin
      $display("** name_to_id_register_lookup_table_core: PASSED **");
    end else begin
      $display("** name_to_id_register_lookup_table_core: FAILED **");
    end
    $finish;
  end

  // Hard stop: a lost reply or a hung handshake ends up here.
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("** name_to_id_register_lookup_table_core: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/nametbl_pkg.sv
hdl/nametbl_cell.sv
hdl/name_to_id_register_lookup_table_core.sv
tb/sv/testbench.sv
